[hw/rtl/keyword_token_scanner_top_defines.svh]
// Assertion macros for the checker file of the token scanner.
`ifndef KEYWORD_TOKEN_SCANNER_TOP_DEFINES_SVH
`define KEYWORD_TOKEN_SCANNER_TOP_DEFINES_SVH

// Plain concurrent check on the rising clock edge.
`define KTS_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kts check failed");

// Concurrent check that is masked while reset is asserted.
`define KTS_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kts check failed");

`endif

[hw/rtl/kts_pkg.sv]
// Types, codes and keyword tables for the keyword token scanner.
package kts_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int VALUE_WIDTH    = 32;
  localparam int LENGTH_WIDTH   = 16;
  localparam int NUM_KW         = 7;
  localparam int OQ_DEPTH       = 4;
  localparam int OQ_PTR_W       = $clog2(OQ_DEPTH);

  // Item commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Token kinds
  localparam logic [4:0] KIND_ID     = 5'd0;
  localparam logic [4:0] KIND_NUM    = 5'd1;
  localparam logic [4:0] KIND_PLUS   = 5'd2;
  localparam logic [4:0] KIND_MINUS  = 5'd3;
  localparam logic [4:0] KIND_MULT   = 5'd4;
  localparam logic [4:0] KIND_DIV    = 5'd5;
  localparam logic [4:0] KIND_EQ     = 5'd6;
  localparam logic [4:0] KIND_SEMI   = 5'd7;
  localparam logic [4:0] KIND_LPAREN = 5'd8;
  localparam logic [4:0] KIND_RPAREN = 5'd9;
  localparam logic [4:0] KIND_LT     = 5'd10;
  localparam logic [4:0] KIND_ASSIGN = 5'd11;
  localparam logic [4:0] KIND_IF     = 5'd12;
  localparam logic [4:0] KIND_EOF    = 5'd19;
  localparam logic [4:0] KIND_ERR    = 5'd20;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic [4:0]                kind;
    logic [POSITION_WIDTH-1:0] start_offset;
    logic [LENGTH_WIDTH-1:0]   token_length;
    logic [VALUE_WIDTH-1:0]    number_value;
    logic [7:0]                bad_char;
    logic                      last;
  } out_t;

  // Results of one item, packed to the front: n of them are valid
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Keyword text, character i at bits [8*i +: 8]
  function automatic logic [47:0] kw_word(input logic [2:0] k);
    logic [47:0] w;
    case (k)
      3'd0:    w = {32'h0, "fi"};
      3'd1:    w = {16'h0, "neht"};
      3'd2:    w = "taeper";
      3'd3:    w = {8'h0, "litnu"};
      3'd4:    w = {16'h0, "daer"};
      3'd5:    w = {8'h0, "etirw"};
      3'd6:    w = {24'h0, "dne"};
      default: w = 48'h0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd2;
      3'd1:    n = 3'd4;
      3'd2:    n = 3'd6;
      3'd3:    n = 3'd5;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd5;
      3'd6:    n = 3'd3;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Drop every candidate whose keyword disagrees at this position
  function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cands,
                                                  input logic [LENGTH_WIDTH-1:0] idx,
                                                  input logic [7:0] c);
    logic [NUM_KW-1:0] r;
    logic [47:0]       w;
    r = cands;
    for (int k = 0; k < NUM_KW; k++) begin
      w = kw_word(3'(k));
      if (idx >= LENGTH_WIDTH'(kw_len(3'(k))) || w[8*idx[2:0] +: 8] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/kts_core.sv]
// Scanner state and per-item token logic.
module kts_core
  import kts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  in_t   item,
  output push_t push
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_ID,
    MODE_COLON
  } mode_t;

  mode_t                     mode_r, mode_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [POSITION_WIDTH-1:0] tstart_r, tstart_nxt;
  logic [LENGTH_WIDTH-1:0]   rlen_r, rlen_nxt;
  logic [VALUE_WIDTH-1:0]    acc_r, acc_nxt;
  logic [NUM_KW-1:0]         cand_r, cand_nxt;

  logic [7:0]             c;
  logic [VALUE_WIDTH+3:0] acc_x10;
  logic [LENGTH_WIDTH-1:0] rlen_inc;
  logic                   fl_v, sd_v;
  out_t                   fl_res, sd_res;
  logic [4:0]             id_kind;

  assign c        = item.byte_in;
  assign acc_x10  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                  + (VALUE_WIDTH + 4)'(c[3:0]);
  assign rlen_inc = (rlen_r == '1) ? rlen_r : rlen_r + 1'b1;

  // Kind of the pending identifier: a surviving candidate of full length
  always_comb begin
    id_kind = KIND_ID;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand_r[k] && rlen_r == LENGTH_WIDTH'(kw_len(3'(k)))) begin
        id_kind = KIND_IF + 5'(k);
      end
    end
  end

  // Token that the pending state yields when it is closed
  always_comb begin
    fl_res              = '0;
    fl_res.start_offset = tstart_r;
    fl_res.token_length = rlen_r;
    case (mode_r)
      MODE_NUM: begin
        fl_res.kind         = KIND_NUM;
        fl_res.number_value = acc_r;
      end
      MODE_ID: begin
        fl_res.kind = id_kind;
      end
      MODE_COLON: begin
        fl_res.kind         = KIND_ERR;
        fl_res.token_length = LENGTH_WIDTH'(1);
        fl_res.bad_char     = CH_COLON;
      end
      default: begin
        fl_res.kind = KIND_ID;
      end
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    rlen_nxt   = rlen_r;
    acc_nxt    = acc_r;
    cand_nxt   = cand_r;
    fl_v       = 1'b0;
    sd_v       = 1'b0;
    sd_res     = '0;
    sd_res.start_offset = pos_r;
    sd_res.token_length = LENGTH_WIDTH'(1);
    if (go) begin
      if (item.cmd == CMD_END) begin
        fl_v                = (mode_r != MODE_IDLE);
        sd_v                = 1'b1;
        sd_res.kind         = KIND_EOF;
        sd_res.token_length = '0;
        mode_nxt   = MODE_IDLE;
        pos_nxt    = '0;
        tstart_nxt = '0;
        rlen_nxt   = '0;
        acc_nxt    = '0;
        cand_nxt   = '1;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (mode_r == MODE_NUM && is_digit(c)) begin
          acc_nxt  = (acc_x10[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0) ? '1
                                                                 : acc_x10[VALUE_WIDTH-1:0];
          rlen_nxt = rlen_inc;
        end else if (mode_r == MODE_ID && (is_alpha(c) || is_digit(c))) begin
          cand_nxt = kw_filter(cand_r, rlen_r, c);
          rlen_nxt = rlen_inc;
        end else if (mode_r == MODE_COLON && c == CH_EQ) begin
          sd_v                = 1'b1;
          sd_res.kind         = KIND_ASSIGN;
          sd_res.start_offset = tstart_r;
          sd_res.token_length = LENGTH_WIDTH'(2);
          mode_nxt            = MODE_IDLE;
        end else begin
          fl_v     = (mode_r != MODE_IDLE);
          mode_nxt = MODE_IDLE;
          if (is_space(c)) begin
            sd_v = 1'b0;
          end else if (is_digit(c)) begin
            mode_nxt   = MODE_NUM;
            tstart_nxt = pos_r;
            rlen_nxt   = LENGTH_WIDTH'(1);
            acc_nxt    = VALUE_WIDTH'(c[3:0]);
          end else if (is_alpha(c)) begin
            mode_nxt   = MODE_ID;
            tstart_nxt = pos_r;
            rlen_nxt   = LENGTH_WIDTH'(1);
            cand_nxt   = kw_filter('1, '0, c);
          end else if (c == CH_COLON) begin
            mode_nxt   = MODE_COLON;
            tstart_nxt = pos_r;
          end else begin
            sd_v = 1'b1;
            case (c)
              CH_PLUS:   sd_res.kind = KIND_PLUS;
              CH_MINUS:  sd_res.kind = KIND_MINUS;
              CH_STAR:   sd_res.kind = KIND_MULT;
              CH_SLASH:  sd_res.kind = KIND_DIV;
              CH_EQ:     sd_res.kind = KIND_EQ;
              CH_SEMI:   sd_res.kind = KIND_SEMI;
              CH_LPAREN: sd_res.kind = KIND_LPAREN;
              CH_RPAREN: sd_res.kind = KIND_RPAREN;
              CH_LT:     sd_res.kind = KIND_LT;
              default: begin
                sd_res.kind     = KIND_ERR;
                sd_res.bad_char = c;
              end
            endcase
          end
        end
      end
    end
  end

  // Pack the results to the front and mark the final one
  always_comb begin
    push         = '0;
    push.n       = {1'b0, fl_v} + {1'b0, sd_v};
    push.r0      = fl_v ? fl_res : sd_res;
    push.r0.last = !(fl_v && sd_v);
    push.r1      = sd_res;
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      rlen_r   <= '0;
      acc_r    <= '0;
      cand_r   <= '1;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      rlen_r   <= rlen_nxt;
      acc_r    <= acc_nxt;
      cand_r   <= cand_nxt;
    end
  end

endmodule

[hw/rtl/kts_outq.sv]
// Result queue: takes up to two results a cycle, hands out one.
module kts_outq
  import kts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space_two,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  out_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_PTR_W:0]   count_r;
  logic                pop;
  logic [OQ_PTR_W-1:0] wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_two = (count_r <= (OQ_PTR_W + 1)'(OQ_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(pop);
      count_r  <= count_r + (OQ_PTR_W + 1)'(push.n) - (OQ_PTR_W + 1)'(pop);
    end
  end

endmodule

[hw/rtl/keyword_token_scanner_top.sv]
// Keyword token scanner: one source byte per item in, tokens out.
// The item that closes a token is held in the input register, then its tokens are written
// into the registered result queue that drives out_valid; that write waits while space_two is low.
// Throughput: one item per cycle while each item yields at most one token and the output is
// not stalled; an item that yields two tokens (a flush plus its own) slows the input, since the result
// queue hands out one token a cycle and the input is held while it has fewer than two free slots.
// Reset (rst_n low, synchronous): empty queues, scanner idle at byte offset zero.
module keyword_token_scanner_top
  import kts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Input register: holds the accepted item until the scanner consumes it
  in_t   in_r;
  logic  in_valid_r;
  logic  space_two;
  logic  go;
  push_t push;

  // Consume the held item only when the queue can take both possible tokens
  assign go       = in_valid_r && space_two;
  // Take a new item whenever the held one is consumed this cycle or none is held
  assign in_ready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; load it on every accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Scanner: updates mode, offsets and keyword candidates, builds the tokens
  kts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_r),
    .push  (push)
  );

  // Result queue: parts the scanner from the downstream stall
  kts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_two (space_two),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/kts_checker.sv]
// Port-level checks for the keyword token scanner, bound to the top level.
`include "keyword_token_scanner_top_defines.svh"

module kts_checker
  import kts_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic out_stall;
  logic eof_v;
  logic not_num_v;
  logic not_err_v;

  assign out_stall = out_valid && !out_ready;
  assign eof_v     = out_valid && (out_data.kind == KIND_EOF);
  assign not_num_v = out_valid && (out_data.kind != KIND_NUM);
  assign not_err_v = out_valid && (out_data.kind != KIND_ERR);

  `KTS_ASSERT(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready)
  `KTS_ASSERT_RST(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data))
  `KTS_ASSERT_RST(a_eof_last, clk, rst_n, eof_v |-> out_data.last && out_data.token_length == '0)
  `KTS_ASSERT_RST(a_value_only_num, clk, rst_n, not_num_v |-> out_data.number_value == '0)
  `KTS_ASSERT_RST(a_bad_only_err, clk, rst_n, not_err_v |-> out_data.bad_char == 8'h00)

endmodule

bind keyword_token_scanner_top kts_checker u_kts_checker (.*);

[verif/keyword_token_scanner_top_test.sv]
// Self-checking testbench for the keyword token scanner: directed table and random streams.
module keyword_token_scanner_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kts_pkg::*;

  // Give up well past the slowest legal run.
  localparam int CYCLE_LIMIT = 200_000;
  // Length of the output hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES = 400;
  // Items per random phase.
  localparam int PHASE_ITEMS = 375;

  localparam logic [VALUE_WIDTH-1:0]  VAL_MAX = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {LEX_IDLE, LEX_NUM, LEX_WORD, LEX_COLON} lex_mode_e;

  // One row of the directed table: the item, plus a typed-in token where it is obvious.
  typedef struct {
    in_t  item;
    logic known;
    out_t want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  keyword_token_scanner_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Keyword spellings, indexed the same way as the kind codes counted from KIND_IF.
  string kw_spell [NUM_KW] = '{"if", "then", "repeat", "until", "read", "write", "end"};

  // Scanner state mirrored by the predictor.
  lex_mode_e                 lex_mode;
  logic [POSITION_WIDTH-1:0] scan_pos;
  logic [POSITION_WIDTH-1:0] tok_start;
  logic [LENGTH_WIDTH-1:0]   tok_len;
  logic [VALUE_WIDTH-1:0]    num_acc;
  logic [NUM_KW-1:0]         kw_live;

  out_t        expected_tokens [$];  // tokens predicted but not yet seen on the output
  int          last_made;            // tokens produced by the most recent item
  in_t         src_pending [$];      // bytes of the random fragment being fed in
  script_row_t script [$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_given     = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int tokens_seen    = 0;
  int bad_count      = 0;
  int cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens still expected", cycle_count,
               expected_tokens.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic digit_ch(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic letter_ch(logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic out_t mk_tok(logic [4:0] kind, logic [POSITION_WIDTH-1:0] start,
                                  logic [LENGTH_WIDTH-1:0] len, logic [VALUE_WIDTH-1:0] val,
                                  logic [7:0] bad, logic fin);
    out_t t;
    t.kind         = kind;
    t.start_offset = start;
    t.token_length = len;
    t.number_value = val;
    t.bad_char     = bad;
    t.last         = fin;
    return t;
  endfunction

  // Clear every keyword candidate that disagrees with character c at position idx.
  function automatic logic [NUM_KW-1:0] narrow_kw(logic [NUM_KW-1:0] live, int idx,
                                                  logic [7:0] c);
    logic [NUM_KW-1:0] r;
    r = live;
    for (int k = 0; k < NUM_KW; k++) begin
      if (idx >= kw_spell[k].len() || kw_spell[k].getc(idx) != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  task automatic emit_tok(logic [4:0] kind, logic [POSITION_WIDTH-1:0] start,
                          logic [LENGTH_WIDTH-1:0] len, logic [VALUE_WIDTH-1:0] val,
                          logic [7:0] bad);
    expected_tokens.push_back(mk_tok(kind, start, len, val, bad, 1'b0));
    last_made++;
  endtask

  task automatic clear_scanner();
    lex_mode  = LEX_IDLE;
    scan_pos  = '0;
    tok_start = '0;
    tok_len   = '0;
    num_acc   = '0;
    kw_live   = '1;
  endtask

  // Emit the token under construction, if any, and drop back to idle.
  task automatic flush_token();
    logic [4:0] kind;
    case (lex_mode)
      LEX_NUM: emit_tok(KIND_NUM, tok_start, tok_len, num_acc, 8'h00);
      LEX_WORD: begin
        kind = KIND_ID;
        for (int k = 0; k < NUM_KW; k++) begin
          if (kw_live[k] && int'(tok_len) == kw_spell[k].len()) kind = KIND_IF + 5'(k);
        end
        emit_tok(kind, tok_start, tok_len, '0, 8'h00);
      end
      LEX_COLON: emit_tok(KIND_ERR, tok_start, LENGTH_WIDTH'(1), '0, CH_COLON);
      default: ;
    endcase
    lex_mode = LEX_IDLE;
  endtask

  // Scan a byte from the idle state.
  task automatic open_token(logic [7:0] c);
    logic [4:0] kind;
    kind = KIND_ERR;
    if (blank_ch(c)) begin
      return;
    end
    if (digit_ch(c)) begin
      lex_mode  = LEX_NUM;
      tok_start = scan_pos;
      tok_len   = LENGTH_WIDTH'(1);
      num_acc   = VALUE_WIDTH'(c) - VALUE_WIDTH'(8'h30);
      return;
    end
    if (letter_ch(c)) begin
      lex_mode  = LEX_WORD;
      tok_start = scan_pos;
      tok_len   = LENGTH_WIDTH'(1);
      kw_live   = narrow_kw('1, 0, c);
      return;
    end
    case (c)
      CH_PLUS:   kind = KIND_PLUS;
      CH_MINUS:  kind = KIND_MINUS;
      CH_STAR:   kind = KIND_MULT;
      CH_SLASH:  kind = KIND_DIV;
      CH_EQ:     kind = KIND_EQ;
      CH_SEMI:   kind = KIND_SEMI;
      CH_LPAREN: kind = KIND_LPAREN;
      CH_RPAREN: kind = KIND_RPAREN;
      CH_LT:     kind = KIND_LT;
      CH_COLON: begin
        lex_mode  = LEX_COLON;
        tok_start = scan_pos;
        return;
      end
      default: ;
    endcase
    if (kind == KIND_ERR) emit_tok(KIND_ERR, scan_pos, LENGTH_WIDTH'(1), '0, c);
    else emit_tok(kind, scan_pos, LENGTH_WIDTH'(1), '0, 8'h00);
  endtask

  // Advance the mirrored scanner by one accepted item and queue the tokens it yields.
  task automatic scan_item(in_t it);
    logic [7:0]             c;
    logic [VALUE_WIDTH-1:0] d;
    out_t                   t;
    c = it.byte_in;
    last_made = 0;
    if (it.cmd == CMD_END) begin
      flush_token();
      emit_tok(KIND_EOF, scan_pos, '0, '0, 8'h00);
      clear_scanner();
    end else begin
      if (lex_mode == LEX_NUM && digit_ch(c)) begin
        d = VALUE_WIDTH'(c) - VALUE_WIDTH'(8'h30);
        if (num_acc > (VAL_MAX - d) / 10) num_acc = VAL_MAX;
        else num_acc = num_acc * 10 + d;
        if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
      end else if (lex_mode == LEX_WORD && (letter_ch(c) || digit_ch(c))) begin
        kw_live = narrow_kw(kw_live, int'(tok_len), c);
        if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
      end else if (lex_mode == LEX_COLON && c == CH_EQ) begin
        emit_tok(KIND_ASSIGN, tok_start, LENGTH_WIDTH'(2), '0, 8'h00);
        lex_mode = LEX_IDLE;
      end else begin
        flush_token();
        open_token(c);
      end
      scan_pos = scan_pos + 1'b1;
    end
    // Mark the final token of this item.
    if (last_made > 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic in_t byte_item(logic [7:0] c);
    in_t it;
    it.cmd     = CMD_BYTE;
    it.byte_in = c;
    return it;
  endfunction

  function automatic in_t end_item();
    in_t it;
    it.cmd     = CMD_END;
    it.byte_in = 8'($urandom_range(255));  // ignored by the block; toggle it anyway
    return it;
  endfunction

  // Offer one item, hold it until accepted, then advance the predictor.
  task automatic send_item(in_t it);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    scan_item(it);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    return 8'h30 + 8'(r - 52);
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(8))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_EQ;
      5:       return CH_SEMI;
      6:       return CH_LPAREN;
      7:       return CH_RPAREN;
      default: return CH_LT;
    endcase
  endfunction

  // Append one source fragment: mostly well-formed tokens, some noise and broken ones.
  task automatic gen_fragment();
    int         pick;
    int         k;
    int         n;
    logic       upper;
    logic       chop;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // keyword, now and then miscased, cut short or extended
      k     = $urandom_range(NUM_KW - 1);
      upper = ($urandom_range(9) == 0);
      chop  = ($urandom_range(9) == 0);
      n     = kw_spell[k].len() - (chop ? 1 : 0);
      for (int i = 0; i < n; i++) begin
        c = kw_spell[k].getc(i);
        if (i == 0 && upper) c = c ^ 8'h20;
        src_pending.push_back(byte_item(c));
      end
      if ($urandom_range(9) == 0) src_pending.push_back(byte_item(rand_alnum()));
    end else if (pick < 45) begin
      c = rand_alnum();
      if (!letter_ch(c)) c = 8'h61 + 8'($urandom_range(25));
      src_pending.push_back(byte_item(c));
      n = $urandom_range(7);
      for (int i = 0; i < n; i++) src_pending.push_back(byte_item(rand_alnum()));
    end else if (pick < 62) begin
      // short numbers mostly; long ones can saturate the value
      n = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) src_pending.push_back(byte_item(8'h30 + 8'($urandom_range(9))));
    end else if (pick < 80) begin
      src_pending.push_back(byte_item(rand_op()));
    end else if (pick < 85) begin
      src_pending.push_back(byte_item(CH_COLON));
      src_pending.push_back(byte_item(CH_EQ));
    end else if (pick < 88) begin
      src_pending.push_back(byte_item(CH_COLON));
    end else if (pick < 93) begin
      src_pending.push_back(byte_item(8'($urandom_range(255))));
    end else if (pick < 97) begin
      src_pending.push_back(byte_item(rand_blank()));
    end else begin
      src_pending.push_back(end_item());
    end
    if ($urandom_range(1) == 0) src_pending.push_back(byte_item(rand_blank()));
  endtask

  task automatic random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if (src_pending.size() == 0) gen_fragment();
      send_item(src_pending.pop_front());
    end
  endtask

  function automatic script_row_t plain_row(in_t it);
    script_row_t row;
    row.item  = it;
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) script.push_back(plain_row(byte_item(s.getc(i))));
  endtask

  task automatic put_known(in_t it, out_t want);
    script_row_t row;
    row       = plain_row(it);
    row.known = 1'b1;
    row.want  = want;
    script.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected token: kind %0d off %0d len %0d val %0d bad %02h last %0b",
                   out_data.kind, out_data.start_offset, out_data.token_length,
                   out_data.number_value, out_data.bad_char, out_data.last);
      end else begin
        want = expected_tokens.pop_front();
        if (out_data.kind !== want.kind || out_data.start_offset !== want.start_offset ||
            out_data.token_length !== want.token_length ||
            out_data.number_value !== want.number_value ||
            out_data.bad_char !== want.bad_char || out_data.last !== want.last) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("token mismatch at cycle %0d", cycle_count);
            $display("  got  kind %0d off %0d len %0d val %0d bad %02h last %0b",
                     out_data.kind, out_data.start_offset, out_data.token_length,
                     out_data.number_value, out_data.bad_char, out_data.last);
            $display("  want kind %0d off %0d len %0d val %0d bad %02h last %0b",
                     want.kind, want.start_offset, want.token_length,
                     want.number_value, want.bad_char, want.last);
          end
        end
      end
    end
    // Hold off the output for a long stretch when asked, else stall at random.
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_ready  <= 1'b0;
      hold_given <= hold_asked;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    clear_scanner();

    // Directed table: rows with a typed-in token are read straight off the rules.
    put_known(end_item(), mk_tok(KIND_EOF, '0, '0, '0, 8'h00, 1'b1));
    put_known(byte_item(CH_PLUS),
              mk_tok(KIND_PLUS, POSITION_WIDTH'(0), LENGTH_WIDTH'(1), '0, 8'h00, 1'b1));
    put_known(byte_item(8'h00),
              mk_tok(KIND_ERR, POSITION_WIDTH'(1), LENGTH_WIDTH'(1), '0, 8'h00, 1'b1));
    put_known(byte_item(8'hFF),
              mk_tok(KIND_ERR, POSITION_WIDTH'(2), LENGTH_WIDTH'(1), '0, 8'hFF, 1'b1));
    put_text("if ");         // keyword ended by whitespace
    put_text("IF;");         // uppercase stays an identifier, flushed ahead of the operator
    put_text(":=");          // assignment
    put_text(":(");          // lone colon error, then the next byte scanned anew
    put_text("4294967296");  // one past the value range: saturates
    put_text(":");           // number flush plus a colon left hanging at the end mark
    script.push_back(plain_row(end_item()));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_item(script[i].item);
      if (script[i].known) begin
        repeat (last_made) void'(expected_tokens.pop_back());
        expected_tokens.push_back(script[i].want);
      end
    end

    // Random streams under each idling mix.
    send_gap_pct = 0;  recv_stall_pct = 0;  random_stream(PHASE_ITEMS);
    send_gap_pct = 62; recv_stall_pct = 0;  random_stream(PHASE_ITEMS);
    send_gap_pct = 0;  recv_stall_pct = 62; random_stream(PHASE_ITEMS);
    send_gap_pct = 15; recv_stall_pct = 15; random_stream(PHASE_ITEMS);

    // Back-pressure: freeze the output while the sender keeps pushing.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_asked <= hold_asked + 1;
    random_stream(200);
    send_item(end_item());

    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    // Wait on for any stray token.
    repeat (20) @(posedge clk);

    $display("summary: %0d items sent, %0d tokens checked, %0d mismatches", items_sent,
             tokens_seen, bad_count);
    $display("summary: directed table, four idle mixes of random source, long output stall");
    if (bad_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
